// ----- sv/tfa_pkg.sv -----
// tfa_pkg: shared types and constants of the turbine flow allocator
// word layouts of the record and result channels, status and outcome codes
// no dependencies
package tfa_pkg;

  localparam int FLOW_W = 22;
  localparam int DEM_W  = 25;
  localparam int TOL_W  = 10;
  localparam int IDX_W  = 6;
  localparam int CODE_W = 3;
  localparam int ST_W   = 2;

  // turbine status encoding
  localparam logic [ST_W-1:0] ST_RUNNING = 2'd0;
  localparam logic [ST_W-1:0] ST_MAINT   = 2'd1;

  // outcome codes
  localparam logic [CODE_W-1:0] OC_OK        = 3'd0;
  localparam logic [CODE_W-1:0] OC_NO_TURB   = 3'd1;
  localparam logic [CODE_W-1:0] OC_ALL_UNAV  = 3'd2;
  localparam logic [CODE_W-1:0] OC_SAT_HIGH  = 3'd3;
  localparam logic [CODE_W-1:0] OC_NO_REDUCE = 3'd4;

  typedef struct packed {
    logic              entry_present;
    logic [ST_W-1:0]   turbine_status;
    logic              status_override;
    logic [ST_W-1:0]   imposed_status;
    logic              flow_override;
    logic [FLOW_W-1:0] imposed_flow;
    logic [FLOW_W-1:0] min_flow;
    logic [FLOW_W-1:0] max_flow;
    logic [FLOW_W-1:0] measured_flow;
    logic [DEM_W-1:0]  total_demand;
    logic              last_entry;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  turbine_index;
    logic [FLOW_W-1:0] turbine_flow;
    logic [DEM_W-1:0]  bypass_flow;
    logic              feasible;
    logic [CODE_W-1:0] outcome_code;
    logic              last_result;
  } out_word_t;

  // one stored turbine entry
  typedef struct packed {
    logic [FLOW_W-1:0] lo;
    logic [FLOW_W-1:0] hi;
    logic [FLOW_W-1:0] base;
  } rec_t;

  // conditioned record with its headroom
  typedef struct packed {
    rec_t              rec;
    logic [FLOW_W-1:0] up_margin;
    logic [FLOW_W-1:0] down_margin;
  } cond_t;

endpackage

// ----- sv/turbine_flow_allocator.sv -----
// turbine_flow_allocator: top level, entry memory and run sequencer
// depends on tfa_pkg, tfa_loader, tfa_divider
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-----------------------------------
//  records  | start, busy, in_word          | word taken when start & !busy
//  results  | out_strobe, out_word          | one cycle per word, no back-pressure
//  config   | cfg_we, cfg_wdata             | match_tolerance written when cfg_we
//
// records are taken one per cycle while busy is low; the word marked last starts
// a run and raises busy. run: a decide state; when flows are rebalanced, a
// bit-serial proportional share per turbine, then a read and an output state per
// result word; the divider and the single-read entry memory set the run length.
// reset is synchronous; it clears counts and sums, memory contents are not reset.
module turbine_flow_allocator #(
  parameter int MAX_TURBINES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  tfa_pkg::in_word_t            in_word,
  output logic                         out_strobe,
  output tfa_pkg::out_word_t           out_word,
  input  logic                         cfg_we,
  input  logic [tfa_pkg::TOL_W-1:0]    cfg_wdata
);
  import tfa_pkg::*;

  localparam int CNT_W = $clog2(MAX_TURBINES + 1);
  localparam int AW    = (MAX_TURBINES > 1) ? $clog2(MAX_TURBINES) : 1;
  localparam int SUM_W = FLOW_W + CNT_W;
  localparam int CMP_W = ((SUM_W > DEM_W) ? SUM_W : DEM_W) + 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_TURBINES);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_P1_RD, S_P1_GO, S_P1_WAIT, S_P2_RD, S_P2_OUT
  } state_t;

  typedef enum logic [1:0] { M_KEEP, M_ZERO, M_UP, M_DOWN } mode_t;

  state_t            state_r;
  mode_t             mode_r;
  logic [TOL_W-1:0]  tol_r;
  logic [CNT_W-1:0]  count_r, n_r, idx_r;
  logic [SUM_W-1:0]  sum_max_r, sum_base_r, sum_up_r, sum_down_r;
  logic [SUM_W-1:0]  scale_r, div_r, total_r;
  logic [DEM_W-1:0]  demand_r, bypass_r;
  logic              feas_r;
  logic [CODE_W-1:0] code_r;
  logic              out_strobe_r;
  out_word_t         out_word_r;

  rec_t              mem [MAX_TURBINES];
  rec_t              rd_q, wr_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  cond_t             cond;
  logic              accept, do_load;
  logic              div_start, div_done;
  logic [FLOW_W-1:0] div_q, new_flow, div_margin;

  logic [CMP_W-1:0]  dem_x, sb_x, gap, d_x, cap_x, tot_x;

  tfa_loader u_loader (
    .in_word (in_word),
    .cond    (cond)
  );

  tfa_divider #(.SUM_W(SUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .scale    (scale_r),
    .divisor  (div_r),
    .margin   (div_margin),
    .done     (div_done),
    .quotient (div_q)
  );

  // headroom of the entry being shared, zero where limits are inverted
  always_comb begin
    if (mode_r == M_UP) begin
      div_margin = (rd_q.hi > rd_q.base) ? rd_q.hi - rd_q.base : '0;
    end else begin
      div_margin = (rd_q.base > rd_q.lo) ? rd_q.base - rd_q.lo : '0;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign do_load   = accept && in_word.entry_present && (count_r < MAX_N);
  assign div_start = (state_r == S_P1_GO);
  assign new_flow  = (mode_r == M_UP) ? rd_q.base + div_q : rd_q.base - div_q;

  // entry memory: one write port, registered read at the run index
  always_comb begin
    wr_en   = do_load || (state_r == S_P1_WAIT && div_done);
    wr_addr = do_load ? count_r[AW-1:0] : idx_r[AW-1:0];
    wr_data = do_load ? cond.rec : '{lo: rd_q.lo, hi: rd_q.hi, base: new_flow};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[idx_r[AW-1:0]];
  end

  // demand against base sum
  always_comb begin
    dem_x = CMP_W'(demand_r);
    sb_x  = CMP_W'(sum_base_r);
    gap   = (sb_x > dem_x) ? sb_x - dem_x : dem_x - sb_x;
    d_x   = (dem_x > sb_x) ? dem_x - sb_x : sb_x - dem_x;
    cap_x = (dem_x > sb_x) ? CMP_W'(sum_up_r) : CMP_W'(sum_down_r);
    cap_x = (d_x < cap_x) ? d_x : cap_x;
    tot_x = CMP_W'(total_r) + CMP_W'(new_flow);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // run sequencer with registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      sum_max_r    <= '0;
      sum_base_r   <= '0;
      sum_up_r     <= '0;
      sum_down_r   <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (do_load) begin
            count_r    <= count_r + 1'b1;
            sum_max_r  <= sum_max_r + SUM_W'(cond.rec.hi);
            sum_base_r <= sum_base_r + SUM_W'(cond.rec.base);
            sum_up_r   <= sum_up_r + SUM_W'(cond.up_margin);
            sum_down_r <= sum_down_r + SUM_W'(cond.down_margin);
          end
          if (accept && in_word.last_entry) begin
            demand_r <= in_word.total_demand;
            state_r  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          n_r        <= count_r;
          idx_r      <= '0;
          total_r    <= '0;
          scale_r    <= cap_x[SUM_W-1:0];
          div_r      <= (dem_x > sb_x) ? sum_up_r : sum_down_r;
          count_r    <= '0;
          sum_max_r  <= '0;
          sum_base_r <= '0;
          sum_up_r   <= '0;
          sum_down_r <= '0;
          feas_r     <= 1'b1;
          code_r     <= OC_OK;
          bypass_r   <= (dem_x > sb_x) ? DEM_W'(d_x) : '0;
          mode_r     <= M_KEEP;
          state_r    <= S_P2_RD;
          if (count_r == '0) begin
            out_strobe_r <= 1'b1;
            out_word_r   <= '{turbine_index: '0, turbine_flow: '0,
                              bypass_flow: demand_r, feasible: 1'b0,
                              outcome_code: OC_NO_TURB, last_result: 1'b1};
            state_r      <= S_IDLE;
          end else if (sum_max_r == '0) begin
            mode_r   <= M_ZERO;
            feas_r   <= 1'b0;
            code_r   <= OC_ALL_UNAV;
            bypass_r <= demand_r;
          end else if (gap > CMP_W'(tol_r)) begin
            if (dem_x > sb_x) begin
              if (sum_up_r == '0) begin
                feas_r <= 1'b0;
                code_r <= OC_SAT_HIGH;
              end else begin
                mode_r  <= M_UP;
                state_r <= S_P1_RD;
              end
            end else begin
              if (sum_down_r == '0) begin
                feas_r <= 1'b0;
                code_r <= OC_NO_REDUCE;
              end else begin
                mode_r  <= M_DOWN;
                state_r <= S_P1_RD;
              end
            end
          end
        end
        S_P1_RD: begin
          state_r <= S_P1_GO;
        end
        S_P1_GO: begin
          state_r <= S_P1_WAIT;
        end
        S_P1_WAIT: begin
          if (div_done) begin
            total_r <= tot_x[SUM_W-1:0];
            if (idx_r + 1'b1 == n_r) begin
              bypass_r <= (dem_x > tot_x) ? DEM_W'(dem_x - tot_x) : '0;
              idx_r    <= '0;
              state_r  <= S_P2_RD;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_P1_RD;
            end
          end
        end
        S_P2_RD: begin
          state_r <= S_P2_OUT;
        end
        S_P2_OUT: begin
          out_strobe_r <= 1'b1;
          out_word_r   <= '{turbine_index: IDX_W'(idx_r),
                            turbine_flow: (mode_r == M_ZERO) ? '0 : rd_q.base,
                            bypass_flow: bypass_r, feasible: feas_r,
                            outcome_code: code_r,
                            last_result: (idx_r + 1'b1 == n_r)};
          if (idx_r + 1'b1 == n_r) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_P2_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ----- sv/tfa_loader.sv -----
// tfa_loader: turns one turbine record into its allowed interval and base flow
// depends on tfa_pkg
module tfa_loader (
  input  tfa_pkg::in_word_t in_word,
  output tfa_pkg::cond_t    cond
);
  import tfa_pkg::*;

  logic              blocked;
  logic [FLOW_W-1:0] lo, hi, forced, t_m, base;

  // blocked when imposed non-running, or reported maintenance
  assign blocked = in_word.status_override ? (in_word.imposed_status != ST_RUNNING)
                                           : (in_word.turbine_status == ST_MAINT);

  // forced flow clamped into the limits, lower bound wins
  always_comb begin
    forced = (in_word.imposed_flow < in_word.max_flow) ? in_word.imposed_flow
                                                       : in_word.max_flow;
    forced = (forced > in_word.min_flow) ? forced : in_word.min_flow;
    if (blocked) begin
      lo = '0;
      hi = '0;
    end else if (in_word.flow_override) begin
      lo = forced;
      hi = forced;
    end else begin
      lo = in_word.min_flow;
      hi = in_word.max_flow;
    end
  end

  // measured flow clamped into the interval, zero when the upper limit is zero
  always_comb begin
    t_m  = (in_word.measured_flow < hi) ? in_word.measured_flow : hi;
    t_m  = (t_m > lo) ? t_m : lo;
    base = (hi == '0) ? '0 : t_m;
  end

  assign cond.rec.lo      = lo;
  assign cond.rec.hi      = hi;
  assign cond.rec.base    = base;
  assign cond.up_margin   = (hi > base) ? hi - base : '0;
  assign cond.down_margin = (base > lo) ? base - lo : '0;

endmodule

// ----- sv/tfa_divider.sv -----
// tfa_divider: iterative proportional share, floor(scale * margin / divisor)
// one margin bit per cycle, scale <= divisor assumed; depends on tfa_pkg
module tfa_divider #(
  parameter int SUM_W = 26
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SUM_W-1:0]          scale,
  input  logic [SUM_W-1:0]          divisor,
  input  logic [tfa_pkg::FLOW_W-1:0] margin,
  output logic                      done,
  output logic [tfa_pkg::FLOW_W-1:0] quotient
);
  import tfa_pkg::*;

  localparam int CNT_W = $clog2(FLOW_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(FLOW_W);

  logic [SUM_W-1:0]  scale_r, div_r, acc_r, acc_nxt;
  logic [FLOW_W-1:0] m_r, q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [SUM_W+1:0]  acc_t, one_s, two_s;
  logic [1:0]        digit;

  // one step: shift in a scaled margin bit, reduce below the divisor
  always_comb begin
    acc_t = {1'b0, acc_r, 1'b0} + (m_r[FLOW_W-1] ? {2'b00, scale_r} : '0);
    one_s = {2'b00, div_r};
    two_s = {1'b0, div_r, 1'b0};
    if (acc_t >= two_s) begin
      digit = 2'd2;
      acc_t = acc_t - two_s;
    end else if (acc_t >= one_s) begin
      digit = 2'd1;
      acc_t = acc_t - one_s;
    end else begin
      digit = 2'd0;
    end
    acc_nxt = acc_t[SUM_W-1:0];
    q_nxt   = {q_r[FLOW_W-2:0], 1'b0} + FLOW_W'(digit);
  end

  // step counter and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r   <= STEPS;
        scale_r <= scale;
        div_r   <= divisor;
        m_r     <= margin;
        acc_r   <= '0;
        q_r     <= '0;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        acc_r  <= acc_nxt;
        q_r    <= q_nxt;
        m_r    <= {m_r[FLOW_W-2:0], 1'b0};
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- verif/tb_turbine_flow_allocator.sv -----
// tb_turbine_flow_allocator: self-checking bench for the turbine flow allocator
// predicts each result word from its own model of the block and checks the out channel
// depends on tfa_pkg and turbine_flow_allocator
module tb_turbine_flow_allocator;
  import tfa_pkg::*;

  localparam int NTURB = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_strobe;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  turbine_flow_allocator #(.MAX_TURBINES(NTURB)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [TOL_W-1:0] tol_reg;
  logic [63:0] lo_mem [NTURB];
  logic [63:0] hi_mem [NTURB];
  logic [63:0] base_mem [NTURB];
  int unsigned n_loaded;
  logic [63:0] tot_hi, tot_base, tot_up, tot_down;

  out_word_t expected_words[$];
  int mismatches = 0;
  bit failed = 0;
  int burst_left = 0;

  function automatic logic [63:0] clamp_flow(logic [63:0] v, logic [63:0] lo,
                                             logic [63:0] hi);
    logic [63:0] t;
    t = (v < hi) ? v : hi;
    return (t > lo) ? t : lo;
  endfunction

  function automatic void clear_set();
    n_loaded = 0;
    tot_hi = 0;
    tot_base = 0;
    tot_up = 0;
    tot_down = 0;
  endfunction

  function automatic void push_word(int k, logic [63:0] flow, logic [63:0] byp,
                                    logic feas, logic [CODE_W-1:0] code, logic last);
    out_word_t w;
    w.turbine_index = k[IDX_W-1:0];
    w.turbine_flow = flow[FLOW_W-1:0];
    w.bypass_flow = byp[DEM_W-1:0];
    w.feasible = feas;
    w.outcome_code = code;
    w.last_result = last;
    expected_words.push_back(w);
  endfunction

  // allocation model: load one record, then share out demand on the last one
  function automatic void predict_allocation(in_word_t w);
    logic [63:0] lo, hi, b, dem, gap, d, amt, m, total, byp;
    logic [63:0] flow [NTURB];
    logic blocked, feas;
    logic [CODE_W-1:0] code;
    if (w.entry_present && n_loaded < NTURB) begin
      lo = w.min_flow;
      hi = w.max_flow;
      blocked = w.status_override ? (w.imposed_status != ST_RUNNING)
                                  : (w.turbine_status == ST_MAINT);
      if (blocked) begin
        lo = 0;
        hi = 0;
      end else if (w.flow_override) begin
        lo = clamp_flow(w.imposed_flow, lo, hi);
        hi = lo;
      end
      b = (hi == 0) ? 0 : clamp_flow(w.measured_flow, lo, hi);
      lo_mem[n_loaded] = lo;
      hi_mem[n_loaded] = hi;
      base_mem[n_loaded] = b;
      tot_hi += hi;
      tot_base += b;
      tot_up += (hi > b) ? hi - b : 0;
      tot_down += (b > lo) ? b - lo : 0;
      n_loaded++;
    end
    if (!w.last_entry) return;
    dem = w.total_demand;
    if (n_loaded == 0) begin
      push_word(0, 0, dem, 1'b0, OC_NO_TURB, 1'b1);
    end else if (tot_hi == 0) begin
      for (int i = 0; i < n_loaded; i++)
        push_word(i, 0, dem, 1'b0, OC_ALL_UNAV, i + 1 == n_loaded);
    end else begin
      feas = 1'b1;
      code = OC_OK;
      for (int i = 0; i < n_loaded; i++) flow[i] = base_mem[i];
      gap = (tot_base > dem) ? tot_base - dem : dem - tot_base;
      if (gap > tol_reg) begin
        if (dem > tot_base) begin
          if (tot_up == 0) begin
            feas = 1'b0;
            code = OC_SAT_HIGH;
          end else begin
            d = dem - tot_base;
            amt = (d < tot_up) ? d : tot_up;
            for (int i = 0; i < n_loaded; i++) begin
              m = (hi_mem[i] > base_mem[i]) ? hi_mem[i] - base_mem[i] : 0;
              flow[i] = base_mem[i] + (amt * m) / tot_up;
            end
          end
        end else begin
          if (tot_down == 0) begin
            feas = 1'b0;
            code = OC_NO_REDUCE;
          end else begin
            d = tot_base - dem;
            amt = (d < tot_down) ? d : tot_down;
            for (int i = 0; i < n_loaded; i++) begin
              m = (base_mem[i] > lo_mem[i]) ? base_mem[i] - lo_mem[i] : 0;
              flow[i] = base_mem[i] - (amt * m) / tot_down;
            end
          end
        end
      end
      total = 0;
      for (int i = 0; i < n_loaded; i++) total += flow[i];
      byp = (dem > total) ? dem - total : 0;
      for (int i = 0; i < n_loaded; i++)
        push_word(i, flow[i], byp, feas, code, i + 1 == n_loaded);
    end
    clear_set();
  endfunction

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_word);
      end else begin
        e = expected_words.pop_front();
        if (out_word !== e) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_word);
        end
      end
    end
  end

  // send one record word, with bursty gaps before it
  task automatic send_word(in_word_t w);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len != 0) begin
        start <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_word <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_allocation(w);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8 * (FLOW_W + 3) + 40) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    tol_reg = v;
  endtask

  function automatic logic [FLOW_W-1:0] rand_flow();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return FLOW_W'($urandom_range(0, 64));
      default: return FLOW_W'($urandom_range(0, 32'h3F_FFFF));
    endcase
  endfunction

  function automatic in_word_t rand_record(logic last);
    in_word_t w;
    logic [FLOW_W-1:0] a, b;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.entry_present = 1'b1;
    w.status_override = ($urandom_range(0, 3) == 0);
    w.flow_override = ($urandom_range(0, 4) == 0);
    a = rand_flow();
    b = rand_flow();
    // mostly ordered limits, sometimes inverted
    if ($urandom_range(0, 7) != 0 && a > b) begin
      w.min_flow = b;
      w.max_flow = a;
    end else begin
      w.min_flow = a;
      w.max_flow = b;
    end
    w.measured_flow = rand_flow();
    w.imposed_flow = rand_flow();
    w.last_entry = last;
    return w;
  endfunction

  // send a set of n records, demand chosen near the expected sum at times
  task automatic send_set(int n, logic [DEM_W-1:0] dem, bit near_sum);
    in_word_t w;
    logic [63:0] s;
    s = 0;
    for (int i = 0; i < n; i++) begin
      w = rand_record(i == n - 1);
      if (i == n - 1) begin
        if (near_sum) begin
          s = tot_base + ((w.max_flow > w.measured_flow) ? w.measured_flow : w.max_flow);
          s = s + $urandom_range(0, 2 * tol_reg + 2) - tol_reg - 1;
          w.total_demand = s[DEM_W-1:0];
        end else begin
          w.total_demand = dem;
        end
      end
      send_word(w);
    end
  endtask

  task automatic test_special_cases();
    in_word_t w;
    // empty set
    w = '0;
    w.last_entry = 1'b1;
    w.total_demand = '1;
    send_word(w);
    // lone non-record item does nothing
    w = '0;
    w.total_demand = 25'h155_5555;
    send_word(w);
    // all blocked: maintenance and imposed stop
    w = '0;
    w.entry_present = 1'b1;
    w.turbine_status = ST_MAINT;
    w.max_flow = '1;
    w.measured_flow = '1;
    send_word(w);
    w.turbine_status = 2'd3;
    w.status_override = 1'b1;
    w.imposed_status = 2'd2;
    w.last_entry = 1'b1;
    w.total_demand = 25'd5000;
    send_word(w);
    // stopped but not overridden stays available; saturated high
    w = '0;
    w.entry_present = 1'b1;
    w.turbine_status = 2'd2;
    w.min_flow = 22'd100;
    w.max_flow = '1;
    w.measured_flow = '1;
    w.last_entry = 1'b1;
    w.total_demand = '1;
    send_word(w);
    // cannot reduce: forced flow, demand zero
    w.flow_override = 1'b1;
    w.imposed_flow = 22'd3000;
    w.total_demand = '0;
    send_word(w);
    // inverted limits and zero maximum
    w = '0;
    w.entry_present = 1'b1;
    w.min_flow = 22'd5000;
    w.max_flow = 22'd1000;
    w.measured_flow = 22'd7;
    send_word(w);
    w.min_flow = 22'd0;
    w.max_flow = 22'd0;
    w.measured_flow = '1;
    send_word(w);
    w.min_flow = 22'd0;
    w.max_flow = 22'd8000;
    w.measured_flow = 22'd100;
    w.status_override = 1'b1;
    w.imposed_status = ST_RUNNING;
    w.turbine_status = ST_MAINT;
    w.last_entry = 1'b1;
    w.total_demand = 25'd20000;
    send_word(w);
  endtask

  task automatic test_overflow_records();
    // more than eight records: extra ones ignored, last still ends the set
    send_set(11, 25'd1_000_000, 1'b0);
    send_set(8, '1, 1'b0);
  endtask

  task automatic test_random_sets(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: send_set(n, DEM_W'($urandom_range(0, 32'h1FF_FFFF)), 1'b0);
        1: send_set(n, DEM_W'($urandom_range(0, 32'h3F_FFFF)), 1'b0);
        default: send_set(n, '0, 1'b1);
      endcase
      sent += n;
    end
  endtask

  initial begin
    tol_reg = 10'd1;
    clear_set();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_special_cases();
    test_overflow_records();
    write_tolerance(10'd0);
    test_random_sets(100);
    write_tolerance(10'd1023);
    test_random_sets(100);
    write_tolerance(10'd37);
    test_random_sets(100);
    write_tolerance(10'd1);
    test_random_sets(80);
    wait_idle();
    if (!failed && expected_words.size() == 0)
      $display("PASS turbine_flow_allocator");
    else
      $display("FAIL turbine_flow_allocator");
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("FAIL turbine_flow_allocator");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tfa_pkg.sv
sv/tfa_loader.sv
sv/tfa_divider.sv
sv/turbine_flow_allocator.sv
verif/tb_turbine_flow_allocator.sv
